// File: design/tstu_pkg.sv
// Package: constants, codes and result type of the TDMA transmit slot timer.
`timescale 1ns / 1ps
`default_nettype none
package tstu_pkg;
  localparam int TIME_WIDTH_DEFAULT = 32;
  localparam int LEN_W   = 20;
  localparam int SPF_W   = 9;
  localparam int OWN_W   = 8;
  localparam int GUARD_W = 16;
  localparam int PKT_W   = 20;
  localparam int LAT_W   = 16;
  localparam int OUT_W   = 32;
  localparam int CIDX_W  = 8;
  localparam int CDATA_W = 32;

  localparam logic [LEN_W-1:0]   LEN_RESET   = 20'd1000;
  localparam logic [SPF_W-1:0]   SPF_RESET   = 9'd4;
  localparam logic [OWN_W-1:0]   OWN_RESET   = 8'd0;
  localparam logic [GUARD_W-1:0] GUARD_RESET = 16'd0;

  localparam logic [CIDX_W-1:0] REG_SLOT_LENGTH     = 8'd0;
  localparam logic [CIDX_W-1:0] REG_SLOTS_PER_FRAME = 8'd1;
  localparam logic [CIDX_W-1:0] REG_OWN_SLOT        = 8'd2;
  localparam logic [CIDX_W-1:0] REG_GUARD_TIME      = 8'd3;

  localparam logic [1:0] VERDICT_SEND  = 2'd0;
  localparam logic [1:0] VERDICT_WAIT  = 2'd1;
  localparam logic [1:0] VERDICT_NOFIT = 2'd2;

  localparam logic signed [33:0] WAIT_MAX = 34'sd2147483647;

  typedef struct packed {
    logic [1:0]              verdict;
    logic signed [OUT_W-1:0] wait_time;
    logic [OUT_W-1:0]        slot_number;
    logic                    in_own_slot;
  } res_t;
endpackage
`default_nettype wire

// File: design/tstu_if.sv
// Channel interfaces: input words, result words and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface tstu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_now;
  logic [19:0] packet_duration;
  logic [15:0] tx_latency;
  modport source (output valid, time_now, packet_duration, tx_latency, input ready);
  modport sink   (input valid, time_now, packet_duration, tx_latency, output ready);
endinterface

interface tstu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [31:0] wait_time;
  logic [31:0] slot_number;
  logic        in_own_slot;
  modport source (output valid, verdict, wait_time, slot_number, in_own_slot, input ready);
  modport sink   (input valid, verdict, wait_time, slot_number, in_own_slot, output ready);
endinterface

interface tstu_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/tdma_transmit_slot_timer_unit.sv
// Top level of the TDMA transmit slot timer.
//
// Takes one query word per cycle while the output skid register is empty and
// returns one result word per query, in order. The time is split into slot
// number and offset by a row of TIME_WIDTH restoring division cells (one
// quotient bit per cell); a second row of TIME_WIDTH cells reduces the slot
// number modulo the frame size. Two decision stages and the output register
// follow. An output skid register holds one result while the output stalls;
// once it is full the whole pipe halts and no query is taken. Configuration
// writes are always taken and should be made while no query is in flight. A
// slot length or frame size of zero behaves as one.
`timescale 1ns / 1ps
`default_nettype none
module tdma_transmit_slot_timer_unit
  import tstu_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tstu_in_if.sink    in_ch,
  tstu_out_if.source out_ch,
  tstu_cfg_if.sink   cfg_ch
);
  localparam int SIDE1_W = PKT_W + LAT_W;
  localparam int SIDE2_W = SIDE1_W + LEN_W + TIME_WIDTH;

  logic [LEN_W-1:0]   len_r;
  logic [SPF_W-1:0]   spf_r;
  logic [OWN_W-1:0]   own_r;
  logic [GUARD_W-1:0] guard_r;
  logic [LEN_W-1:0]   len_eff;
  logic [SPF_W-1:0]   spf_eff;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_RESET;
      spf_r   <= SPF_RESET;
      own_r   <= OWN_RESET;
      guard_r <= GUARD_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SLOT_LENGTH:     len_r   <= cfg_ch.data[LEN_W-1:0];
        REG_SLOTS_PER_FRAME: spf_r   <= cfg_ch.data[SPF_W-1:0];
        REG_OWN_SLOT:        own_r   <= cfg_ch.data[OWN_W-1:0];
        REG_GUARD_TIME:      guard_r <= cfg_ch.data[GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (len_r == '0) ? LEN_W'(1) : len_r;
  assign spf_eff = (spf_r == '0) ? SPF_W'(1) : spf_r;

  // output register plus skid word; the whole pipe halts while the skid is full
  logic  skid_v_r, out_v_r;
  res_t  skid_r, out_r;
  logic  en, take;
  logic  pipe_v;
  res_t  pipe_res;

  assign en          = !skid_v_r;
  assign take        = out_ch.ready || !out_v_r;
  assign in_ch.ready = en;

  logic                  c1_v;
  logic [LEN_W-1:0]      c1_rem;
  logic [TIME_WIDTH-1:0] c1_quo;
  logic [SIDE1_W-1:0]    c1_side;

  tstu_div_chain #(.NW(TIME_WIDTH), .DW(LEN_W), .SW(SIDE1_W)) u_slot_div (
    .clk(clk), .rst_n(rst_n), .en(en), .divisor(len_eff),
    .in_valid(in_ch.valid && en),
    .in_num(TIME_WIDTH'(in_ch.time_now)),
    .in_side({in_ch.packet_duration, in_ch.tx_latency}),
    .out_valid(c1_v), .out_rem(c1_rem), .out_quo(c1_quo), .out_side(c1_side)
  );

  logic                  c2_v;
  logic [SPF_W-1:0]      c2_rem;
  logic [SIDE2_W-1:0]    c2_side;

  tstu_div_chain #(.NW(TIME_WIDTH), .DW(SPF_W), .SW(SIDE2_W)) u_frame_mod (
    .clk(clk), .rst_n(rst_n), .en(en), .divisor(spf_eff),
    .in_valid(c1_v), .in_num(c1_quo),
    .in_side({c1_side, c1_rem, c1_quo}),
    .out_valid(c2_v), .out_rem(c2_rem), .out_quo(), .out_side(c2_side)
  );

  tstu_decide #(.TW(TIME_WIDTH)) u_decide (
    .clk(clk), .rst_n(rst_n), .en(en),
    .len(len_eff), .spf(spf_eff), .own_slot(own_r), .guard(guard_r),
    .in_valid(c2_v), .index(c2_rem),
    .offset(c2_side[TIME_WIDTH +: LEN_W]),
    .slot_abs(c2_side[TIME_WIDTH-1:0]),
    .pkt(c2_side[SIDE2_W-1 -: PKT_W]),
    .txlat(c2_side[TIME_WIDTH+LEN_W +: LAT_W]),
    .out_valid(pipe_v), .out_res(pipe_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (take) begin
      out_v_r <= pipe_v;
    end else if (pipe_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) out_r <= skid_r;
    end else if (take) begin
      out_r <= pipe_res;
    end else begin
      skid_r <= pipe_res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.verdict     = out_r.verdict;
  assign out_ch.wait_time   = out_r.wait_time;
  assign out_ch.slot_number = out_r.slot_number;
  assign out_ch.in_own_slot = out_r.in_own_slot;
endmodule
`default_nettype wire

// File: design/tstu_div_cell.sv
// One restoring division cell: takes one numerator bit, yields one quotient bit.
`timescale 1ns / 1ps
`default_nettype none
module tstu_div_cell #(
  parameter int NW = 32,
  parameter int DW = 20,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic [DW-1:0] divisor,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [NW-1:0] in_quo,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      out_num,
  output logic [DW-1:0]      out_rem,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);
  logic          valid_r;
  logic [NW-1:0] num_r, quo_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] side_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial   = {in_rem, in_num[NW-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= {in_num[NW-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quo_r  <= {in_quo[NW-2:0], ge};
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_num   = num_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_side  = side_r;
endmodule
`default_nettype wire

// File: design/tstu_div_chain.sv
// Row of division cells, one per numerator bit, remainder passed cell to cell.
`timescale 1ns / 1ps
`default_nettype none
module tstu_div_chain #(
  parameter int NW = 32,
  parameter int DW = 20,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic [DW-1:0] divisor,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [DW-1:0]      out_rem,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);
  logic [NW:0]         v;
  logic [NW:0][NW-1:0] num, quo;
  logic [NW:0][DW-1:0] rem;
  logic [NW:0][SW-1:0] side;

  assign v[0]    = in_valid;
  assign num[0]  = in_num;
  assign rem[0]  = '0;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    tstu_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .divisor(divisor),
      .in_valid(v[k]), .in_num(num[k]), .in_rem(rem[k]), .in_quo(quo[k]),
      .in_side(side[k]),
      .out_valid(v[k+1]), .out_num(num[k+1]), .out_rem(rem[k+1]),
      .out_quo(quo[k+1]), .out_side(side[k+1])
    );
  end

  assign out_valid = v[NW];
  assign out_rem   = rem[NW];
  assign out_quo   = quo[NW];
  assign out_side  = side[NW];
endmodule
`default_nettype wire

// File: design/tstu_decide.sv
// Verdict stages: frame distance, slot multiply, wait sum and clamp.
`timescale 1ns / 1ps
`default_nettype none
module tstu_decide
  import tstu_pkg::*;
#(
  parameter int TW = TIME_WIDTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic [LEN_W-1:0]   len,
  input  wire logic [SPF_W-1:0]   spf,
  input  wire logic [OWN_W-1:0]   own_slot,
  input  wire logic [GUARD_W-1:0] guard,
  input  wire logic               in_valid,
  input  wire logic [SPF_W-1:0]   index,
  input  wire logic [LEN_W-1:0]   offset,
  input  wire logic [TW-1:0]      slot_abs,
  input  wire logic [PKT_W-1:0]   pkt,
  input  wire logic [LAT_W-1:0]   txlat,
  output logic                    out_valid,
  output res_t                    out_res
);
  // stage A: distance to own slot
  logic             a_valid_r;
  logic [SPF_W-1:0] a_mult_r;
  logic             a_own_r;
  logic [LEN_W-1:0] a_left_r, a_elapsed_r;
  logic [TW-1:0]    a_slot_r;
  logic [PKT_W-1:0] a_pkt_r;
  logic [LAT_W-1:0] a_lat_r;
  logic [SPF_W:0]   diff;
  logic [SPF_W-1:0] slot_gap, a_mult_nxt;
  logic             a_own_nxt;

  always_comb begin
    diff       = {2'b00, own_slot} - {1'b0, index};
    slot_gap   = diff[SPF_W] ? (diff[SPF_W-1:0] + spf) : diff[SPF_W-1:0];
    a_own_nxt  = (slot_gap == '0);
    a_mult_nxt = a_own_nxt ? (spf - 1'b1) : (slot_gap - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mult_r    <= a_mult_nxt;
      a_own_r     <= a_own_nxt;
      a_left_r    <= len - offset;
      a_elapsed_r <= offset;
      a_slot_r    <= slot_abs;
      a_pkt_r     <= pkt;
      a_lat_r     <= txlat;
    end
  end

  // stage B: slot multiply and fit tests
  logic                    b_valid_r;
  logic [LEN_W+SPF_W-1:0]  b_prod_r;
  logic                    b_nofit_r, b_send_r, b_own_r;
  logic signed [22:0]      b_short_r;
  logic [LEN_W-1:0]        b_left_r;
  logic [TW-1:0]           b_slot_r;
  logic [LAT_W-1:0]        b_lat_r;
  logic signed [22:0]      maxtx, pkt_s;
  logic [21:0]             need;

  always_comb begin
    maxtx = $signed({3'b000, len}) - $signed({6'b0, guard, 1'b0});
    pkt_s = $signed({3'b000, a_pkt_r});
    need  = {2'b00, a_pkt_r} + {6'b0, guard} + {6'b0, a_lat_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod_r  <= a_mult_r * len;
      b_nofit_r <= (pkt_s > maxtx);
      b_short_r <= maxtx - pkt_s;
      b_send_r  <= a_own_r
                   && (({1'b0, a_elapsed_r} + {5'b0, a_lat_r}) >= {5'b0, guard})
                   && ({2'b00, a_left_r} >= need);
      b_own_r   <= a_own_r;
      b_left_r  <= a_left_r;
      b_slot_r  <= a_slot_r;
      b_lat_r   <= a_lat_r;
    end
  end

  // final: wait sum and clamp, registered by the output stage
  logic signed [33:0] wsum;
  logic signed [33:0] wclamp;

  always_comb begin
    wsum = $signed({14'b0, b_left_r}) + $signed({5'b0, b_prod_r})
         + $signed({18'b0, guard}) - $signed({18'b0, b_lat_r});
    priority if (wsum < 0) begin
      wclamp = '0;
    end else if (wsum > WAIT_MAX) begin
      wclamp = WAIT_MAX;
    end else begin
      wclamp = wsum;
    end
    out_res.slot_number = OUT_W'(b_slot_r);
    out_res.in_own_slot = b_own_r;
    priority if (b_nofit_r) begin
      out_res.verdict   = VERDICT_NOFIT;
      out_res.wait_time = OUT_W'(b_short_r);
    end else if (b_send_r) begin
      out_res.verdict   = VERDICT_SEND;
      out_res.wait_time = '0;
    end else begin
      out_res.verdict   = VERDICT_WAIT;
      out_res.wait_time = wclamp[OUT_W-1:0];
    end
  end

  assign out_valid = b_valid_r;
endmodule
`default_nettype wire

// File: design/tstu_checker.sv
// Port checker for the slot timer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tstu_port_props
  import tstu_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_verdict,
  input wire logic [31:0] out_wait_time
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict != 2'd3)
    else $error("undefined verdict");
  a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_SEND |-> out_wait_time == '0)
    else $error("send word with non-zero wait");
  a_nofit_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_NOFIT |-> out_wait_time[31])
    else $error("no-fit word without negative shortfall");
  a_wait_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_WAIT |-> !out_wait_time[31])
    else $error("wait word with negative wait");
endmodule

bind tdma_transmit_slot_timer_unit tstu_port_props u_tstu_port_props (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_verdict(out_ch.verdict), .out_wait_time(out_ch.wait_time)
);
`default_nettype wire
